[rtl/core/cm_pkg.sv]
package cm_pkg;

	localparam int MAX_TRIALS    = 16;
	localparam int MAX_POSITIONS = 64;
	localparam int SAMPLE_BITS   = 32;

	localparam int TRIAL_W  = $clog2(MAX_TRIALS);
	localparam int POS_W    = $clog2(MAX_POSITIONS);
	localparam int TCNT_W   = 5;
	localparam int PCNT_W   = 7;
	localparam int ADDR_W   = TRIAL_W + POS_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_TRIAL_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_COUNT = 1'd1;

	localparam logic ACT_STORE   = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [3:0]  trial;
		logic [5:0]  position;
		logic [31:0] sample;
	} in_beat_t;

	typedef struct packed {
		logic [5:0]  result_position;
		logic [31:0] median;
		logic        last;
	} out_beat_t;

	typedef struct packed {
		logic clear;
		logic insert;
	} chain_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

[rtl/core/cm_cell.sv]
module cm_cell
	import cm_pkg::*;
(
	input  logic                   clk,
	input  logic                   insert,
	input  logic                   occupied,
	input  logic [SAMPLE_BITS-1:0] new_val,
	input  logic [SAMPLE_BITS-1:0] left_val,
	input  logic                   left_lt,
	output logic [SAMPLE_BITS-1:0] val,
	output logic                   lt
);

	logic [SAMPLE_BITS-1:0] val_q;

	// An empty cell behaves as if it held a value above every sample.
	assign lt  = !occupied || (new_val < val_q);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (insert && lt) begin
			val_q <= left_lt ? left_val : new_val;
		end
	end

endmodule

[rtl/core/cm_chain.sv]
module cm_chain
	import cm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  chain_ctrl_t            ctrl,
	input  logic [SAMPLE_BITS-1:0] new_val,
	input  logic [TCNT_W-1:0]      n,
	output logic [SAMPLE_BITS-1:0] median
);

	logic [TCNT_W-1:0]      cnt_q;
	logic [SAMPLE_BITS-1:0] vals [MAX_TRIALS];
	logic                   lts  [MAX_TRIALS];
	logic [TRIAL_W-1:0]     half;
	logic [TRIAL_W-1:0]     half_m1;
	logic [SAMPLE_BITS:0]   pair_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.clear) begin
			cnt_q <= '0;
		end else if (ctrl.insert) begin
			cnt_q <= cnt_q + TCNT_W'(1);
		end
	end

	for (genvar i = 0; i < MAX_TRIALS; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] lv;
		logic                   llt;
		if (i == 0) begin : g_first
			assign lv  = new_val;
			assign llt = 1'b0;
		end else begin : g_rest
			assign lv  = vals[i-1];
			assign llt = lts[i-1];
		end
		cm_cell u_cell (
			.clk      (clk),
			.insert   (ctrl.insert),
			.occupied (TCNT_W'(i) < cnt_q),
			.new_val  (new_val),
			.left_val (lv),
			.left_lt  (llt),
			.val      (vals[i]),
			.lt       (lts[i])
		);
	end

	assign half     = n[TRIAL_W:1];
	assign half_m1  = half - TRIAL_W'(1);
	assign pair_sum = {1'b0, vals[half_m1]} + {1'b0, vals[half]};

	always_comb begin
		if (n[0]) begin
			median = vals[half];
		end else begin
			median = pair_sum[SAMPLE_BITS:1];
		end
	end

endmodule

[rtl/core/columnwise_median.sv]
// Column-wise median over a matrix of trials by positions.
// Input beats on in_data/in_valid/in_ready carry either a store, which writes
// one sample at (trial, position), or a compute, which emits one median per
// position on out_data/out_valid/out_ready, positions in ascending order, with
// last set on the final one. The configuration port sets the trial count and
// the position count; it is to be written only while the block is idle, but
// the block itself does not enforce this. Stores are accepted back to back.
// For a compute, the samples of a position are read from the sample memory
// one per cycle and inserted into a chain of sorting cells, then the median is
// taken from the middle cells. No new input beat is accepted until the last
// median of a compute has been loaded into the output register.
// If the receiver stalls, the block holds its result in the output register,
// reads and sorts the next position meanwhile, and waits with its median until
// the register is free.
// Reset clears the control state and sets both counts to one; the sample
// memory is not cleared, and every entry must be stored before it is read.
module columnwise_median
	import cm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_beat_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SAMPLE_BITS-1:0] sample_store_q [MAX_TRIALS*MAX_POSITIONS];

	state_t                 state_q, state_d;
	logic [TCNT_W-1:0]      trial_count_q;
	logic [PCNT_W-1:0]      position_count_q;
	logic [TCNT_W-1:0]      nt_q;
	logic [PCNT_W-1:0]      np_q;
	logic [TCNT_W-1:0]      nt_c;
	logic [PCNT_W-1:0]      np_c;
	logic [TRIAL_W-1:0]     t_q;
	logic [POS_W-1:0]       p_q;
	logic                   rd_vld_s1;
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic                   out_valid_q;
	out_beat_t              out_q;
	logic [SAMPLE_BITS-1:0] median;
	chain_ctrl_t            chain_ctrl;
	logic                   in_fire;
	logic                   start;
	logic                   out_free;
	logic                   is_last;
	logic                   read_done;
	logic                   rd_en;
	logic                   load_out;

	assign nt_c = (trial_count_q > TCNT_W'(MAX_TRIALS)) ? TCNT_W'(MAX_TRIALS) : trial_count_q;
	assign np_c = (position_count_q > PCNT_W'(MAX_POSITIONS)) ?
		PCNT_W'(MAX_POSITIONS) : position_count_q;

	assign in_fire   = in_valid && in_ready;
	assign start     = in_fire && (in_data.action == ACT_COMPUTE) &&
		(nt_c != '0) && (np_c != '0);
	assign out_free  = !out_valid_q || out_ready;
	assign is_last   = ({1'b0, p_q} == np_q - PCNT_W'(1));
	assign read_done = ({1'b0, t_q} == nt_q - TCNT_W'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (read_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = is_last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_READ: begin
				rd_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_EMIT: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	assign chain_ctrl.clear  = load_out;
	assign chain_ctrl.insert = rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			trial_count_q    <= TCNT_W'(1);
			position_count_q <= PCNT_W'(1);
			rd_vld_s1        <= 1'b0;
			out_valid_q      <= 1'b0;
			t_q              <= '0;
			p_q              <= '0;
			nt_q             <= TCNT_W'(1);
			np_q             <= PCNT_W'(1);
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (cfg_we) begin
				case (cfg_index)
					CFG_TRIAL_COUNT: begin
						trial_count_q <= cfg_data[TCNT_W-1:0];
					end
					CFG_POSITION_COUNT: begin
						position_count_q <= cfg_data[PCNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (start) begin
				nt_q <= nt_c;
				np_q <= np_c;
				t_q  <= '0;
				p_q  <= '0;
			end else if (rd_en) begin
				t_q <= t_q + TRIAL_W'(1);
			end else if (load_out) begin
				t_q <= '0;
				p_q <= p_q + POS_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (in_data.action == ACT_STORE)) begin
			sample_store_q[{in_data.trial, in_data.position}] <= in_data.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= sample_store_q[{t_q, p_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.result_position <= p_q;
			out_q.median          <= median;
			out_q.last            <= is_last;
		end
	end

	cm_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (chain_ctrl),
		.new_val (rd_data_s1),
		.n       (nt_q),
		.median  (median)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
